/* rtl/core/gtt_pkg.sv */
// ----------------------------------------------------------------------------
// gtt_pkg: shared types and constants of the gated track table
// Beat payloads, the track entry kept in each cell, op and register codes.
// ----------------------------------------------------------------------------
package gtt_pkg;

	localparam int COORD_W = 16;
	localparam int RAD_W   = 16;
	localparam int MISS_W  = 4;
	localparam int TOTAL_W = 5;

	localparam logic [MISS_W-1:0] MISS_MAX   = 4'd15;
	localparam logic [RAD_W-1:0]  RADIUS_RST = 16'd384;
	localparam logic [MISS_W-1:0] LIMIT_RST  = 4'd3;

	localparam logic [1:0] OP_AGE   = 2'd0;
	localparam logic [1:0] OP_DET   = 2'd1;
	localparam logic [1:0] OP_EVICT = 2'd2;
	localparam logic [1:0] OP_MARK  = 2'd3;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] entry_x;
		logic signed [COORD_W-1:0] entry_y;
		logic signed [COORD_W-1:0] entry_z;
		logic                      entry_checked;
		logic                      entry_valid;
		logic [TOTAL_W-1:0]        entry_total;
		logic                      all_marked;
		logic                      overflow_seen;
		logic                      last;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               checked;
		logic [MISS_W-1:0]  misses;
	} track_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

/* rtl/core/gated_track_table_with_aging.sv */
// ----------------------------------------------------------------------------
// gated_track_table_with_aging: radius gated track table with miss aging
// Entries sit in a chain of cells that acts as a queue: the head entry is
// popped, worked on, and pushed back behind the live entries, or dropped on evict.
//
//   channel  | valid        | stall        | payload
//   item     | item_valid   | item_stall   | item   (item_t)
//   result   | result_valid | result_stall | result (result_t)
//   config   | APB write at psel & penable & pwrite, pready tied high
//
// An item beat is followed by work on each entry in turn, through the head
// of the chain and the gate multipliers, and then a closing step; the input
// stays stalled until the table is back in idle. An evict or mark item
// then lists one entry per cycle (one beat for an empty table) while the
// result side does not stall; a stalled result holds the listing.
// Reset clears the count and the overflow flag and sets the registers to
// their defaults; entries need no clearing since only live cells are read.
// ----------------------------------------------------------------------------
module gated_track_table_with_aging import gtt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PROC = 2'd1;
	localparam logic [1:0] ST_LIST = 2'd2;

	logic [1:0]         state_q;
	logic [1:0]         op_q;
	logic [COORD_W-1:0] px_q, py_q, pz_q;
	logic [CNT_W-1:0]   pass_n_q, idx_q, cnt_q;
	logic               matched_q, all_q, ovf_q;
	logic [RAD_W-1:0]   radius_q;
	logic [MISS_W-1:0]  limit_q;
	logic [2*RAD_W-1:0] rr_q;
	logic               res_valid_q;
	result_t            res_q;

	track_t     cell_val [TABLE_DEPTH];
	cell_ctrl_t cell_ctrl [TABLE_DEPTH];
	track_t     head, head_mod, push_val;
	logic       keep, hit, take, proc_active, proc_final, list_fire, list_last;
	logic       shift, push_en;
	logic [IDX_W-1:0] push_idx;
	logic [CNT_W-1:0] cnt_m1;

	logic signed [COORD_W:0] dxs, dys;
	logic [COORD_W:0]        dxa, dya;
	logic [2*RAD_W-1:0]      sqx, sqy;
	logic [2*RAD_W:0]        sqsum;
	logic                    cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RADIUS: radius_q <= pwdata[RAD_W-1:0];
				REG_LIMIT:  limit_q  <= pwdata[MISS_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RADIUS: prdata = 32'(radius_q);
			REG_LIMIT:  prdata = 32'(limit_q);
			default:    prdata = '0;
		endcase
	end

	// The squared radius follows the register in the cycle after; the user is to
	// write only while idle (not enforced here), so it settles before the next item.
	always_ff @(posedge clk) begin
		rr_q <= radius_q * radius_q;
	end

	// Distance gate on the head entry.
	assign head = cell_val[0];
	assign dxs  = $signed({head.x[COORD_W-1], head.x}) - $signed({px_q[COORD_W-1], px_q});
	assign dys  = $signed({head.y[COORD_W-1], head.y}) - $signed({py_q[COORD_W-1], py_q});
	assign dxa  = dxs[COORD_W] ? (COORD_W+1)'(0) - dxs : dxs;
	assign dya  = dys[COORD_W] ? (COORD_W+1)'(0) - dys : dys;
	assign sqx  = dxa[RAD_W-1:0] * dxa[RAD_W-1:0];
	assign sqy  = dya[RAD_W-1:0] * dya[RAD_W-1:0];
	assign sqsum = {1'b0, sqx} + {1'b0, sqy};
	assign hit  = (dxa <= {1'b0, radius_q}) && (dya <= {1'b0, radius_q})
		&& (sqsum <= {1'b0, rr_q});

	assign proc_active = (state_q == ST_PROC) && (idx_q != pass_n_q);
	assign proc_final  = (state_q == ST_PROC) && (idx_q == pass_n_q);
	assign take = !matched_q && hit && (op_q == OP_DET || op_q == OP_MARK);

	always_comb begin
		head_mod = head;
		keep     = 1'b1;
		unique case (op_q)
			OP_AGE: begin
				if (head.misses != MISS_MAX) head_mod.misses = head.misses + 1'b1;
			end
			OP_DET: begin
				if (take) begin
					head_mod.x      = px_q;
					head_mod.y      = py_q;
					head_mod.z      = pz_q;
					head_mod.misses = '0;
				end
			end
			OP_EVICT: keep = (head.misses <= limit_q);
			OP_MARK: begin
				if (take) head_mod.checked = 1'b1;
			end
			default: ;
		endcase
	end

	assign list_fire = (state_q == ST_LIST) && (!res_valid_q || !result_stall);
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign list_last = (cnt_q == '0) || (idx_q == cnt_m1);

	// Chain control: a pop shifts every cell toward the head; the worked
	// entry goes behind the entries that are still live.
	always_comb begin
		shift    = 1'b0;
		push_en  = 1'b0;
		push_idx = cnt_m1[IDX_W-1:0];
		push_val = head_mod;
		priority if (proc_active) begin
			shift   = 1'b1;
			push_en = keep;
		end else if (proc_final && op_q == OP_DET && !matched_q
				&& cnt_q < CNT_W'(TABLE_DEPTH)) begin
			push_en  = 1'b1;
			push_idx = cnt_q[IDX_W-1:0];
			push_val = '{x: px_q, y: py_q, z: pz_q, checked: 1'b0, misses: '0};
		end else if (list_fire && cnt_q != '0) begin
			shift    = 1'b1;
			push_en  = 1'b1;
			push_val = head;
		end else begin
			// The chain holds.
		end
	end

	for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
		track_t nxt;
		if (j == TABLE_DEPTH - 1) begin : g_end
			assign nxt = cell_val[j];
		end else begin : g_mid
			assign nxt = cell_val[j+1];
		end
		assign cell_ctrl[j] = '{shift: shift,
			load: push_en && (push_idx == IDX_W'(j))};
		gtt_cell u_cell (
			.clk  (clk),
			.ctrl (cell_ctrl[j]),
			.nxt  (nxt),
			.push (push_val),
			.val  (cell_val[j])
		);
	end

	// Sequencer.
	assign item_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			pass_n_q  <= '0;
			cnt_q     <= '0;
			matched_q <= 1'b0;
			all_q     <= 1'b1;
			ovf_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q   <= ST_PROC;
						idx_q     <= '0;
						pass_n_q  <= cnt_q;
						matched_q <= 1'b0;
						all_q     <= 1'b1;
					end
				end
				ST_PROC: begin
					if (proc_active) begin
						idx_q     <= idx_q + CNT_W'(1);
						cnt_q     <= cnt_q + CNT_W'(keep) - CNT_W'(1);
						matched_q <= matched_q | take;
						if (keep) all_q <= all_q & head_mod.checked;
					end else begin
						if (op_q == OP_DET && !matched_q) begin
							if (cnt_q < CNT_W'(TABLE_DEPTH)) cnt_q <= cnt_q + CNT_W'(1);
							else ovf_q <= 1'b1;
						end
						idx_q   <= '0;
						state_q <= (op_q == OP_EVICT || op_q == OP_MARK) ? ST_LIST : ST_IDLE;
					end
				end
				ST_LIST: begin
					if (list_fire) begin
						idx_q <= idx_q + CNT_W'(1);
						if (list_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			op_q <= item.op;
			px_q <= item.pos_x;
			py_q <= item.pos_y;
			pz_q <= item.pos_z;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (list_fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (list_fire) begin
			if (cnt_q == '0) begin
				res_q <= '0;
			end else begin
				res_q.entry_x       <= head.x;
				res_q.entry_y       <= head.y;
				res_q.entry_z       <= head.z;
				res_q.entry_checked <= head.checked;
				res_q.entry_valid   <= 1'b1;
				res_q.entry_total   <= TOTAL_W'(cnt_q);
				res_q.all_marked    <= (op_q == OP_MARK) && all_q;
			end
			res_q.overflow_seen <= ovf_q;
			res_q.last          <= list_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("track count beyond table depth");
	a_accept_proc: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> state_q == ST_PROC)
		else $error("accepted item did not start a pass");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(list_fire && list_last) |=> (state_q == ST_IDLE && res_valid_q && res_q.last))
		else $error("listing did not close on its last beat");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag cleared");

endmodule

/* rtl/core/gtt_cell.sv */
// ----------------------------------------------------------------------------
// gtt_cell: one slot of the track chain
// Takes the entry of its neighbor on a shift, or the pushed entry on a load.
// ----------------------------------------------------------------------------
module gtt_cell import gtt_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  track_t     nxt,
	input  track_t     push,
	output track_t     val
);

	track_t val_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= push;
		end else if (ctrl.shift) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule
